// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the state-variable filter checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside of reset.
`define SVF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg
// Shared widths, register indexes, reset values and control types.
// ----------------------------------------------------------------------------
package svf_pkg;

  localparam int COEF_W          = 15;
  localparam int MODE_W          = 3;
  localparam int SAMPLE_W        = 17;
  localparam int OUT_W           = 21;
  localparam int CFG_IDX_W       = 2;
  localparam int LOW_RANGE_BITS  = 20;
  localparam int BAND_RANGE_BITS = 18;

  localparam int STATE_FRAC_BITS_DEF = 8;
  localparam int COEF_FRAC_BITS_DEF  = 14;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_SELECT = 2'd2;

  localparam logic [COEF_W-1:0] FILTER_COEF_RST = 15'd19661;
  localparam logic [COEF_W-1:0] DAMPING_RST     = 15'd16384;
  localparam logic [MODE_W-1:0] MODE_SELECT_RST = 3'd1;

  typedef enum logic [1:0] {
    MUL_F_BAND,
    MUL_Q_BAND,
    MUL_F_HIGH
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     low_en;
    logic     high_en;
    logic     band_en;
    logic     out_en;
  } svf_cmd_t;

  typedef struct packed {
    logic gate_next;
  } svf_stat_t;

endpackage

// File: design/svf_cfg.sv
// ----------------------------------------------------------------------------
// svf_cfg
// Configuration registers: frequency coefficient, damping and output mode.
// ----------------------------------------------------------------------------
module svf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [svf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svf_pkg::COEF_W-1:0]     cfg_wdata_i,
  output logic [svf_pkg::COEF_W-1:0]     filter_coef_o,
  output logic [svf_pkg::COEF_W-1:0]     damping_o,
  output logic [svf_pkg::MODE_W-1:0]     mode_select_o
);
  import svf_pkg::*;

  logic [COEF_W-1:0] filter_coef_q;
  logic [COEF_W-1:0] damping_q;
  logic [MODE_W-1:0] mode_select_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_coef_q <= FILTER_COEF_RST;
      damping_q     <= DAMPING_RST;
      mode_select_q <= MODE_SELECT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FILTER_COEF: filter_coef_q <= cfg_wdata_i;
        REG_DAMPING:     damping_q     <= cfg_wdata_i;
        REG_MODE_SELECT: mode_select_q <= cfg_wdata_i[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign filter_coef_o = filter_coef_q;
  assign damping_o     = damping_q;
  assign mode_select_o = mode_select_q;

endmodule

// File: design/svf_dp.sv
// ----------------------------------------------------------------------------
// svf_dp
// Filter datapath: state registers, one shared multiplier with a registered
// product, rounding, saturation, block gate and the output register.
// ----------------------------------------------------------------------------
module svf_dp #(
  parameter int STATE_FRAC_BITS = svf_pkg::STATE_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS  = svf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svf_pkg::svf_cmd_t                   cmd_i,
  output svf_pkg::svf_stat_t                  stat_o,
  input  logic signed [svf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                block_start_i,
  input  logic                                routed_i,
  input  logic [svf_pkg::COEF_W-1:0]          filter_coef_i,
  input  logic [svf_pkg::COEF_W-1:0]          damping_i,
  input  logic [svf_pkg::MODE_W-1:0]          mode_select_i,
  output logic signed [svf_pkg::OUT_W-1:0]    filtered_o
);
  import svf_pkg::*;

  localparam int S      = STATE_FRAC_BITS;
  localparam int C      = COEF_FRAC_BITS;
  localparam int LOW_W  = LOW_RANGE_BITS + 1 + S;
  localparam int BAND_W = BAND_RANGE_BITS + 1 + S;
  localparam int QB_W   = COEF_W + BAND_RANGE_BITS + 1 - C;
  localparam int HIGH_W = ((QB_W > LOW_RANGE_BITS + 1) ? QB_W : LOW_RANGE_BITS + 1) + S + 2;
  localparam int MA_W   = COEF_W + 1;
  localparam int PROD_W = HIGH_W + MA_W;
  localparam int EXT_W  = PROD_W + 1;
  localparam int SUM_W  = HIGH_W + 2;

  localparam logic signed [EXT_W-1:0] LOW_HI  = (EXT_W'(1) << (LOW_RANGE_BITS + S)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] LOW_LO  = -(EXT_W'(1) << (LOW_RANGE_BITS + S));
  localparam logic signed [EXT_W-1:0] BAND_HI = (EXT_W'(1) << (BAND_RANGE_BITS + S)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] BAND_LO = -(EXT_W'(1) << (BAND_RANGE_BITS + S));
  localparam logic signed [EXT_W-1:0] RING_HI = EXT_W'(1) << S;
  localparam logic signed [EXT_W-1:0] RING_LO = -(EXT_W'(1) << S);
  localparam logic signed [SUM_W-1:0] OUT_HI  = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] OUT_LO  = -(SUM_W'(1) << (OUT_W - 1));

  logic signed [LOW_W-1:0]    low_q;
  logic signed [BAND_W-1:0]   band_q;
  logic                       run_gate_q;
  logic signed [HIGH_W-1:0]   high_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [OUT_W-1:0]    out_q;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [HIGH_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [EXT_W-1:0]  prod_bias;
  logic signed [EXT_W-1:0]  prod_rnd;
  logic signed [EXT_W-1:0]  low_sum;
  logic signed [EXT_W-1:0]  band_sum;
  logic signed [EXT_W-1:0]  high_d;
  logic signed [LOW_W-1:0]  low_d;
  logic signed [BAND_W-1:0] band_d;
  logic signed [EXT_W-1:0]  low_ext;
  logic signed [EXT_W-1:0]  band_ext;
  logic                     ringing;
  logic                     gate_d;
  logic signed [SUM_W-1:0]  mix;
  logic signed [SUM_W-1:0]  mix_bias;
  logic signed [SUM_W-1:0]  mix_rnd;
  logic signed [SUM_W-1:0]  mix_sat;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_F_BAND: begin
        mul_a = $signed({1'b0, filter_coef_i});
        mul_b = HIGH_W'(band_q);
      end
      MUL_Q_BAND: begin
        mul_a = $signed({1'b0, damping_i});
        mul_b = HIGH_W'(band_q);
      end
      MUL_F_HIGH: begin
        mul_a = $signed({1'b0, filter_coef_i});
        mul_b = high_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d    = mul_a * mul_b;
  assign prod_bias = EXT_W'(prod_q) + (EXT_W'(1) << (C - 1));
  assign prod_rnd  = prod_bias >>> C;

  assign low_ext  = EXT_W'(low_q);
  assign band_ext = EXT_W'(band_q);
  assign low_sum  = low_ext + prod_rnd;
  assign band_sum = band_ext + prod_rnd;
  assign high_d   = (EXT_W'(x_q) <<< S) - low_ext - prod_rnd;

  always_comb begin
    priority if (low_sum > LOW_HI) begin
      low_d = LOW_W'(LOW_HI);
    end else if (low_sum < LOW_LO) begin
      low_d = LOW_W'(LOW_LO);
    end else begin
      low_d = LOW_W'(low_sum);
    end
  end

  always_comb begin
    priority if (band_sum > BAND_HI) begin
      band_d = BAND_W'(BAND_HI);
    end else if (band_sum < BAND_LO) begin
      band_d = BAND_W'(BAND_LO);
    end else begin
      band_d = BAND_W'(band_sum);
    end
  end

  assign ringing = (band_ext > RING_HI) || (band_ext < RING_LO) ||
                   (low_ext > RING_HI) || (low_ext < RING_LO);
  assign gate_d  = block_start_i ? ((mode_select_i != '0) && (routed_i || ringing))
                                 : run_gate_q;
  assign stat_o.gate_next = gate_d;

  always_comb begin
    mix = '0;
    if (mode_select_i[0]) begin
      mix = mix + SUM_W'(low_q);
    end
    if (mode_select_i[1]) begin
      mix = mix + SUM_W'(band_q);
    end
    if (mode_select_i[2]) begin
      mix = mix + SUM_W'(high_q);
    end
  end

  assign mix_bias = mix + (SUM_W'(1) << (S - 1));
  assign mix_rnd  = mix_bias >>> S;

  always_comb begin
    priority if (mix_rnd > OUT_HI) begin
      mix_sat = OUT_HI;
    end else if (mix_rnd < OUT_LO) begin
      mix_sat = OUT_LO;
    end else begin
      mix_sat = mix_rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q      <= '0;
      band_q     <= '0;
      run_gate_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        run_gate_q <= gate_d;
      end
      if (cmd_i.low_en) begin
        low_q <= low_d;
      end
      if (cmd_i.band_en) begin
        band_q <= band_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.high_en) begin
      high_q <= HIGH_W'(high_d);
    end
    if (cmd_i.out_en) begin
      out_q <= run_gate_q ? OUT_W'(mix_sat) : '0;
    end
  end

  assign filtered_o = out_q;

  `include "assert_macros.svh"

  `SVF_ASSERT_NEXT(a_gate_off_holds, !run_gate_q && !cmd_i.load, $stable(low_q) && $stable(band_q), "Filter state changed while the gate is off.")
  `SVF_ASSERT_IMPL(a_update_needs_gate, cmd_i.low_en || cmd_i.band_en || cmd_i.high_en, run_gate_q, "State update issued while the gate is off.")

endmodule

// File: design/svf_ctrl.sv
// ----------------------------------------------------------------------------
// svf_ctrl
// Controller: accepts a request, sequences the shared multiplier through the
// low, high and band updates and owns the output valid flag.
// ----------------------------------------------------------------------------
module svf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output svf_pkg::svf_cmd_t  cmd_o,
  input  svf_pkg::svf_stat_t stat_i
);
  import svf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FB,
    ST_LOW,
    ST_HIGH,
    ST_MUL_FH,
    ST_BAND,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_F_BAND;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.gate_next ? ST_MUL_FB : ST_OUT;
        end
      end
      ST_MUL_FB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_F_BAND;
        state_d       = ST_LOW;
      end
      ST_LOW: begin
        cmd_o.low_en  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Q_BAND;
        state_d       = ST_HIGH;
      end
      ST_HIGH: begin
        cmd_o.high_en = 1'b1;
        state_d       = ST_MUL_FH;
      end
      ST_MUL_FH: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_F_HIGH;
        state_d       = ST_BAND;
      end
      ST_BAND: begin
        cmd_o.band_en = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.out_en) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `include "assert_macros.svh"

  `SVF_ASSERT_IMPL(a_out_load_free, cmd_o.out_en, !out_valid_q || out_ready_i, "Output register overwritten before its request was taken.")
  `SVF_ASSERT_NEXT(a_gated_skip, accept && !stat_i.gate_next, state_q == ST_OUT, "Gated-off request did not go straight to the output.")

endmodule

// File: design/state_variable_filter.sv
// A running sample passes from idle through the multiply, low, high, multiply, band
// and output states, the single shared multiplier serving three dependent products in
// turn; a gated-off sample goes straight to output. New samples are taken only in idle.
// A finished result waits in the output register while the next sample is taken.
// Reset (async, active low) clears both filter states and the gate and loads
// the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// state_variable_filter
// Chamberlin state-variable filter with low, band and high outputs mixed by
// mode, a per-block run gate and a directly configured coefficient and damping.
// ----------------------------------------------------------------------------
module state_variable_filter #(
  parameter int STATE_FRAC_BITS = svf_pkg::STATE_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS  = svf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [svf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                block_start_i,
  input  logic                                routed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [svf_pkg::OUT_W-1:0]    filtered_o,
  input  logic                                cfg_we_i,
  input  logic [svf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [svf_pkg::COEF_W-1:0]          cfg_wdata_i
);
  import svf_pkg::*;

  svf_cmd_t          cmd;
  svf_stat_t         stat;
  logic [COEF_W-1:0] filter_coef;
  logic [COEF_W-1:0] damping;
  logic [MODE_W-1:0] mode_select;

  svf_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .filter_coef_o (filter_coef),
    .damping_o     (damping),
    .mode_select_o (mode_select)
  );

  svf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  svf_dp #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .sample_i      (sample_i),
    .block_start_i (block_start_i),
    .routed_i      (routed_i),
    .filter_coef_i (filter_coef),
    .damping_i     (damping),
    .mode_select_i (mode_select),
    .filtered_o    (filtered_o)
  );

endmodule
